// ===== src/csalu_pkg.sv =====
// ----------------------------------------------------------------------------
// csalu_pkg
// Shared widths, operation and status codes, and pipeline depths for the
// checked signed ALU.
// ----------------------------------------------------------------------------
package csalu_pkg;

  localparam int DataW     = 64;
  localparam int HalfW     = DataW / 2;
  localparam int DivStages = DataW;
  localparam int MulLat    = 4;
  localparam int LastIdx   = DivStages;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_REM = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIV0 = 2'd2
  } status_t;

  // side information that travels next to the divider stages
  typedef struct packed {
    logic             valid;
    logic [2:0]       op;
    logic             na;
    logic             nb;
    logic             use_div;
    logic [DataW-1:0] b;
    logic [DataW-1:0] value;
    logic [1:0]       status;
  } side_t;

endpackage

// ===== src/csalu_mul.sv =====
// ----------------------------------------------------------------------------
// csalu_mul
// Four-stage signed multiply of magnitudes with exact 64-bit overflow check.
// ----------------------------------------------------------------------------
module csalu_mul (
  input  logic                          clk,
  input  logic [csalu_pkg::DataW-1:0]   mag_a,
  input  logic [csalu_pkg::DataW-1:0]   mag_b,
  input  logic                          neg,
  output logic [csalu_pkg::DataW-1:0]   value_r,
  output logic                          ovf_r
);

  localparam int W = csalu_pkg::DataW;
  localparam int H = csalu_pkg::HalfW;

  logic [W-1:0] p00_r, p01_r, p10_r, p11_r;
  logic         neg1_r, neg2_r, neg3_r;
  logic [H+1:0] mid_r;
  logic [H-1:0] lo32_r;
  logic [W-1:0] hip_r;
  logic [W-1:0] hi_r, lo_r;
  logic [H+1:0] mid_nxt;
  logic [W-1:0] hip_nxt;
  logic [W-1:0] limit;

  // form the four partial products
  always_ff @(posedge clk) begin
    p00_r  <= mag_a[H-1:0] * mag_b[H-1:0];
    p01_r  <= mag_a[H-1:0] * mag_b[W-1:H];
    p10_r  <= mag_a[W-1:H] * mag_b[H-1:0];
    p11_r  <= mag_a[W-1:H] * mag_b[W-1:H];
    neg1_r <= neg;
  end

  // gather the middle column and the high part
  always_comb begin
    mid_nxt = {2'b00, p00_r[W-1:H]} + {2'b00, p01_r[H-1:0]} + {2'b00, p10_r[H-1:0]};
    hip_nxt = p11_r + {{H{1'b0}}, p01_r[W-1:H]} + {{H{1'b0}}, p10_r[W-1:H]};
  end

  always_ff @(posedge clk) begin
    mid_r  <= mid_nxt;
    hip_r  <= hip_nxt;
    lo32_r <= p00_r[H-1:0];
    neg2_r <= neg1_r;
  end

  // close the full 128-bit product
  always_ff @(posedge clk) begin
    lo_r   <= {mid_r[H-1:0], lo32_r};
    hi_r   <= hip_r + {{(W-2){1'b0}}, mid_r[H+1:H]};
    neg3_r <= neg2_r;
  end

  // check range and apply sign
  assign limit = neg3_r ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};

  always_ff @(posedge clk) begin
    ovf_r   <= (hi_r != '0) || (lo_r > limit);
    value_r <= neg3_r ? ({W{1'b0}} - lo_r) : lo_r;
  end

endmodule

// ===== src/csalu_div.sv =====
// ----------------------------------------------------------------------------
// csalu_div
// Unsigned restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module csalu_div (
  input  logic                          clk,
  input  logic [csalu_pkg::DataW-1:0]   dividend,
  input  logic [csalu_pkg::DataW-1:0]   divisor,
  output logic [csalu_pkg::DataW-1:0]   quotient,
  output logic [csalu_pkg::DataW-1:0]   remainder
);

  localparam int W = csalu_pkg::DataW;
  localparam int N = csalu_pkg::DivStages;

  logic [W-1:0] rem_r [N];
  logic [W-1:0] nq_r  [N];
  logic [W-1:0] d_r   [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [W-1:0] rem_prev, nq_prev, d_prev;
    logic [W:0]   shifted, diff;
    logic         ge;

    if (i == 0) begin : g_first
      assign rem_prev = '0;
      assign nq_prev  = dividend;
      assign d_prev   = divisor;
    end else begin : g_next
      assign rem_prev = rem_r[i-1];
      assign nq_prev  = nq_r[i-1];
      assign d_prev   = d_r[i-1];
    end

    // trial subtract of the divisor from the shifted remainder
    always_comb begin
      shifted = {rem_prev, nq_prev[W-1]};
      diff    = shifted - {1'b0, d_prev};
      ge      = shifted >= {1'b0, d_prev};
    end

    always_ff @(posedge clk) begin
      rem_r[i] <= ge ? diff[W-1:0] : shifted[W-1:0];
      nq_r[i]  <= {nq_prev[W-2:0], ge};
      d_r[i]   <= d_prev;
    end
  end

  assign quotient  = nq_r[N-1];
  assign remainder = rem_r[N-1];

endmodule

// ===== src/checked_signed_alu_top.sv =====
// ----------------------------------------------------------------------------
// checked_signed_alu_top
// Pipelined signed 64-bit ALU: add, subtract, multiply, divide and floor
// remainder with overflow and divide-by-zero status.
//
//   channel   ports                                     direction
//   request   start, busy, in_operation/operand_a/b     in (busy out)
//   result    out_valid, out_value, out_status          out
//
// One request is taken every cycle; busy is always low.
// The pipeline has one decode stage, 64 divider stages (one quotient
// bit each) and one result stage. The divider depth sets the latency.
// Reset clears the valid bits of all stages; requests in flight are dropped.
// out_valid is a one-cycle strobe; the receiver cannot stall the pipeline.
// ----------------------------------------------------------------------------
module checked_signed_alu_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_operation,
  input  logic [63:0] in_operand_a,
  input  logic [63:0] in_operand_b,
  output logic        out_valid,
  output logic [63:0] out_value,
  output logic [1:0]  out_status
);

  localparam int W = csalu_pkg::DataW;
  localparam int L = csalu_pkg::LastIdx;
  localparam int M = csalu_pkg::MulLat;

  localparam logic [W-1:0] MinVal = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] NegOne = {W{1'b1}};

  csalu_pkg::side_t side_r [L+1];
  csalu_pkg::side_t side0_nxt;
  csalu_pkg::side_t side_mul_nxt;
  logic [W-1:0] mag_a_r, mag_b_r;
  logic         mul_neg_r;
  logic [W-1:0] mul_value;
  logic         mul_ovf;
  logic [W-1:0] quo, rem;
  logic         na, nb;
  logic [W-1:0] sum, dif;
  logic         out_valid_r;
  logic [W-1:0] out_value_r, out_value_nxt;
  logic [1:0]   out_status_r;

  assign busy = 1'b0;
  assign na   = in_operand_a[W-1];
  assign nb   = in_operand_b[W-1];
  assign sum  = in_operand_a + in_operand_b;
  assign dif  = in_operand_a - in_operand_b;

  // decode the request and settle the simple operations
  always_comb begin
    side0_nxt         = '0;
    side0_nxt.valid   = start && !busy;
    side0_nxt.op      = in_operation;
    side0_nxt.na      = na;
    side0_nxt.nb      = nb;
    side0_nxt.b       = in_operand_b;
    side0_nxt.status  = csalu_pkg::ST_OK;
    unique case (in_operation)
      csalu_pkg::OP_ADD: begin
        if (na == nb && sum[W-1] != na) side0_nxt.status = csalu_pkg::ST_OVF;
        else side0_nxt.value = sum;
      end
      csalu_pkg::OP_SUB: begin
        if (na != nb && dif[W-1] != na) side0_nxt.status = csalu_pkg::ST_OVF;
        else side0_nxt.value = dif;
      end
      csalu_pkg::OP_MUL: ;
      csalu_pkg::OP_DIV: begin
        if (in_operand_b == '0) side0_nxt.status = csalu_pkg::ST_DIV0;
        else if (in_operand_a == MinVal && in_operand_b == NegOne)
          side0_nxt.status = csalu_pkg::ST_OVF;
        else side0_nxt.use_div = 1'b1;
      end
      csalu_pkg::OP_REM: begin
        if (in_operand_b == NegOne) side0_nxt.use_div = 1'b0;
        else if (in_operand_b == '0) side0_nxt.status = csalu_pkg::ST_DIV0;
        else side0_nxt.use_div = 1'b1;
      end
      default: ;
    endcase
  end

  // stage 0 registers: operand magnitudes
  always_ff @(posedge clk) begin
    mag_a_r   <= na ? ({W{1'b0}} - in_operand_a) : in_operand_a;
    mag_b_r   <= nb ? ({W{1'b0}} - in_operand_b) : in_operand_b;
    mul_neg_r <= (na != nb) && (in_operand_a != '0) && (in_operand_b != '0);
  end

  csalu_mul u_mul (
    .clk     (clk),
    .mag_a   (mag_a_r),
    .mag_b   (mag_b_r),
    .neg     (mul_neg_r),
    .value_r (mul_value),
    .ovf_r   (mul_ovf)
  );

  csalu_div u_div (
    .clk       (clk),
    .dividend  (mag_a_r),
    .divisor   (mag_b_r),
    .quotient  (quo),
    .remainder (rem)
  );

  // fold in the product when it lands
  always_comb begin
    side_mul_nxt = side_r[M];
    if (side_r[M].op == csalu_pkg::OP_MUL) begin
      side_mul_nxt.status = mul_ovf ? csalu_pkg::ST_OVF : csalu_pkg::ST_OK;
      side_mul_nxt.value  = mul_ovf ? '0 : mul_value;
    end
  end

  // advance side info along the divider
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= L; i++) begin
        side_r[i].valid <= 1'b0;
      end
    end else begin
      side_r[0] <= side0_nxt;
      for (int i = 1; i <= L; i++) begin
        side_r[i] <= (i == M + 1) ? side_mul_nxt : side_r[i-1];
      end
    end
  end

  // sign the quotient or fix the remainder toward the divisor
  always_comb begin
    out_value_nxt = side_r[L].value;
    if (side_r[L].use_div) begin
      if (side_r[L].op == csalu_pkg::OP_DIV) begin
        out_value_nxt = (side_r[L].na != side_r[L].nb) ? ({W{1'b0}} - quo) : quo;
      end else if (rem != '0 && side_r[L].na != side_r[L].nb) begin
        out_value_nxt = side_r[L].na ? (side_r[L].b - rem) : (side_r[L].b + rem);
      end else begin
        out_value_nxt = side_r[L].na ? ({W{1'b0}} - rem) : rem;
      end
    end
  end

  // hold the result for one strobe cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= side_r[L].valid;
    end
    out_value_r  <= out_value_nxt;
    out_status_r <= side_r[L].status;
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

`ifndef SYNTHESIS
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status != 2'd3))
    else $error("status code three produced");

  a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != csalu_pkg::ST_OK) |-> (out_value == '0))
    else $error("nonzero value with error status");

  a_mul_status: assert property (@(posedge clk) disable iff (!rst_n)
    (side_r[M+1].valid && side_r[M+1].op == csalu_pkg::OP_MUL) |->
      (side_r[M+1].status == csalu_pkg::ST_OK || side_r[M+1].status == csalu_pkg::ST_OVF))
    else $error("multiply produced divide status");

  a_div_path: assert property (@(posedge clk) disable iff (!rst_n)
    (side_r[L].valid && side_r[L].use_div) |-> (side_r[L].status == csalu_pkg::ST_OK))
    else $error("divider path taken with error status");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives random and corner-case requests into the checked signed ALU and
// compares every result against a built-in 130-bit arithmetic predictor.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct {
    logic [2:0]  op;
    logic [63:0] a;
    logic [63:0] b;
  } alu_req_t;

  typedef struct {
    logic [63:0] value;
    logic [1:0]  status;
  } alu_res_t;

  localparam int StallLimit = 2000;
  localparam logic [63:0] MinVal = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MaxVal = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NegOne = 64'hFFFF_FFFF_FFFF_FFFF;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_operation;
  logic [63:0] in_operand_a;
  logic [63:0] in_operand_b;
  logic        out_valid;
  logic [63:0] out_value;
  logic [1:0]  out_status;

  alu_req_t pending_reqs[$];
  alu_res_t expected_results[$];
  int       gap_left;
  int       errors;
  int       idle_cycles;
  int       num_accepted;
  int       num_checked;
  bit       stim_done;
  bit       timed_out;

  checked_signed_alu_top u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_operand_a(in_operand_a),
    .in_operand_b(in_operand_b), .out_valid(out_valid),
    .out_value(out_value), .out_status(out_status)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Compute the exact result of one request in wide signed arithmetic
  function automatic alu_res_t alu_predict(alu_req_t r);
    logic signed [129:0] sa, sb, full;
    logic signed [129:0] rem;
    alu_res_t res;
    sa = {{66{r.a[63]}}, r.a};
    sb = {{66{r.b[63]}}, r.b};
    res.value = '0;
    res.status = csalu_pkg::ST_OK;
    full = '0;
    case (r.op)
      csalu_pkg::OP_ADD: full = sa + sb;
      csalu_pkg::OP_SUB: full = sa - sb;
      csalu_pkg::OP_MUL: full = sa * sb;
      csalu_pkg::OP_DIV: begin
        if (sb == 0) res.status = csalu_pkg::ST_DIV0;
        else full = sa / sb;
      end
      csalu_pkg::OP_REM: begin
        if (sb == -1) full = 0;
        else if (sb == 0) res.status = csalu_pkg::ST_DIV0;
        else begin
          rem = sa % sb;
          if (rem != 0 && (rem < 0) != (sb < 0)) rem = rem + sb;
          full = rem;
        end
      end
      default: full = 0;
    endcase
    if (res.status == csalu_pkg::ST_OK &&
        (full > $signed({66'd0, MaxVal}) || full < -$signed({66'd0, MinVal})))
      res.status = csalu_pkg::ST_OVF;
    if (res.status == csalu_pkg::ST_OK) res.value = full[63:0];
    return res;
  endfunction

  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = MinVal;
      1: v = MaxVal;
      2: v = NegOne;
      3: v = '0;
      4: v = {{56{v[63]}}, v[7:0]};
      5: v = {{32{v[63]}}, v[31:0]};
      6: v = {{48{v[63]}}, v[15:0]};
      default: ;
    endcase
    return v;
  endfunction

  task automatic add_req(logic [2:0] op, logic [63:0] a, logic [63:0] b);
    alu_req_t r;
    r.op = op;
    r.a = a;
    r.b = b;
    pending_reqs.push_back(r);
  endtask

  // Fill the request queue: corner cases first, then random traffic
  initial begin
    csalu_pkg::op_t ops[5] = '{csalu_pkg::OP_ADD, csalu_pkg::OP_SUB, csalu_pkg::OP_MUL,
                               csalu_pkg::OP_DIV, csalu_pkg::OP_REM};
    add_req(csalu_pkg::OP_ADD, MaxVal, 64'd1);
    add_req(csalu_pkg::OP_ADD, MinVal, NegOne);
    add_req(csalu_pkg::OP_SUB, MinVal, 64'd1);
    add_req(csalu_pkg::OP_SUB, 64'd0, MinVal);
    add_req(csalu_pkg::OP_SUB, NegOne, MinVal);
    add_req(csalu_pkg::OP_MUL, MinVal, 64'd1);
    add_req(csalu_pkg::OP_MUL, MinVal, NegOne);
    add_req(csalu_pkg::OP_MUL, 64'h0000_0000_8000_0000, 64'hFFFF_FFFF_0000_0000);
    add_req(csalu_pkg::OP_MUL, 64'h0000_0000_8000_0000, 64'h0000_0001_0000_0000);
    add_req(csalu_pkg::OP_MUL, MaxVal, MaxVal);
    add_req(csalu_pkg::OP_DIV, MinVal, NegOne);
    add_req(csalu_pkg::OP_DIV, MaxVal, 64'd0);
    add_req(csalu_pkg::OP_DIV, 64'hFFFF_FFFF_FFFF_FFF9, 64'd2);
    add_req(csalu_pkg::OP_REM, MinVal, NegOne);
    add_req(csalu_pkg::OP_REM, 64'd5, 64'd0);
    add_req(csalu_pkg::OP_REM, 64'hFFFF_FFFF_FFFF_FFF9, 64'd3);
    add_req(csalu_pkg::OP_REM, 64'd7, 64'hFFFF_FFFF_FFFF_FFFD);
    add_req(csalu_pkg::OP_REM, MinVal, MaxVal);
    add_req(3'd5, MaxVal, MaxVal);
    add_req(3'd6, MinVal, NegOne);
    add_req(3'd7, NegOne, 64'd0);
    for (int i = 0; i < 1030; i++) begin
      logic [2:0] op;
      op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                        : ops[$urandom_range(0, 4)];
      add_req(op, rand_operand(), rand_operand());
    end
  end

  // Reset, then wait for the pipeline to drain and report
  initial begin
    rst_n = 1'b0;
    errors = 0;
    stim_done = 1'b0;
    timed_out = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    wait (pending_reqs.size() == 0 && expected_results.size() == 0 && !start);
    repeat (2 * csalu_pkg::LastIdx + 10) @(posedge clk);
    $display("Covered %0d requests across all operations, %0d results checked.",
             num_accepted, num_checked);
    if (errors == 0 && expected_results.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Drive requests at the falling edge, with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_operation <= '0;
      in_operand_a <= '0;
      in_operand_b <= '0;
      gap_left <= 0;
    end else if (start && busy) begin
      // hold the request until it is taken
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_reqs.size() > 0) begin
      alu_req_t r;
      r = pending_reqs.pop_front();
      start <= 1'b1;
      in_operation <= r.op;
      in_operand_a <= r.a;
      in_operand_b <= r.b;
      case ($urandom_range(0, 19))
        0: gap_left <= $urandom_range(20, 120);
        1, 2, 3, 4: gap_left <= $urandom_range(1, 3);
        default: gap_left <= 0;
      endcase
    end else begin
      start <= 1'b0;
    end
  end

  initial begin
    start = 1'b0;
    in_operation = '0;
    in_operand_a = '0;
    in_operand_b = '0;
    gap_left = 0;
  end

  // Record accepted requests and check results at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        alu_req_t r;
        r.op = in_operation;
        r.a = in_operand_a;
        r.b = in_operand_b;
        expected_results.push_back(alu_predict(r));
        num_accepted <= num_accepted + 1;
      end
      if (out_valid) begin
        alu_res_t exp_res;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result value=%h status=%0d",
                   $realtime, out_value, out_status);
          errors = errors + 1;
        end else begin
          exp_res = expected_results.pop_front();
          if (exp_res.value !== out_value) begin
            $display("%0t: value mismatch expected %h actual %h",
                     $realtime, exp_res.value, out_value);
            errors = errors + 1;
          end
          if (exp_res.status !== out_status) begin
            $display("%0t: status mismatch expected %0d actual %0d",
                     $realtime, exp_res.status, out_status);
            errors = errors + 1;
          end
        end
        num_checked <= num_checked + 1;
      end
      // advance the watchdog while nothing moves
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("Watchdog expired with %0d results outstanding",
                 expected_results.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    idle_cycles = 0;
    num_accepted = 0;
    num_checked = 0;
  end

endmodule

// ===== filelist.f =====
src/csalu_pkg.sv
src/csalu_mul.sv
src/csalu_div.sv
src/checked_signed_alu_top.sv
tb/testbench.sv
